/* rtl/core/ebpf_instruction_execute_defines.svh */
// assertion macros for the execute unit checker
`ifndef EBPF_INSTRUCTION_EXECUTE_DEFINES_SVH
`define EBPF_INSTRUCTION_EXECUTE_DEFINES_SVH

`define EIE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define EIE_ASSERT_IMPL(name, ante, cons, msg) \
  `EIE_ASSERT(name, (ante) |-> (cons), msg)

`define EIE_ASSERT_NEXT(name, ante, cons, msg) \
  `EIE_ASSERT(name, (ante) |=> (cons), msg)

`endif

/* rtl/core/ebpf_ie_pkg.sv */
package ebpf_ie_pkg;

  localparam int unsigned STACK_BYTES = 4096;
  localparam int unsigned REG_COUNT   = 11;
  localparam int unsigned XLEN        = 64;
  localparam int unsigned LANES       = 8;
  localparam int unsigned ROWS        = STACK_BYTES / LANES;
  localparam int unsigned ROW_W       = $clog2(ROWS);
  localparam int unsigned BA_W        = $clog2(STACK_BYTES);
  localparam int unsigned REG_AW      = $clog2(REG_COUNT);
  localparam int unsigned FP_REG      = REG_COUNT - 1;

  localparam logic [2:0] CLS_LD    = 3'd0;
  localparam logic [2:0] CLS_LDX   = 3'd1;
  localparam logic [2:0] CLS_ST    = 3'd2;
  localparam logic [2:0] CLS_STX   = 3'd3;
  localparam logic [2:0] CLS_ALU   = 3'd4;
  localparam logic [2:0] CLS_JMP   = 3'd5;
  localparam logic [2:0] CLS_ALU64 = 3'd7;

  localparam logic [3:0] OP_ADD  = 4'h0;
  localparam logic [3:0] OP_SUB  = 4'h1;
  localparam logic [3:0] OP_MUL  = 4'h2;
  localparam logic [3:0] OP_DIV  = 4'h3;
  localparam logic [3:0] OP_OR   = 4'h4;
  localparam logic [3:0] OP_AND  = 4'h5;
  localparam logic [3:0] OP_LSH  = 4'h6;
  localparam logic [3:0] OP_RSH  = 4'h7;
  localparam logic [3:0] OP_NEG  = 4'h8;
  localparam logic [3:0] OP_MOD  = 4'h9;
  localparam logic [3:0] OP_XOR  = 4'ha;
  localparam logic [3:0] OP_MOV  = 4'hb;
  localparam logic [3:0] OP_ARSH = 4'hc;
  localparam logic [3:0] OP_END  = 4'hd;

  localparam logic [3:0] JOP_JA   = 4'h0;
  localparam logic [3:0] JOP_JEQ  = 4'h1;
  localparam logic [3:0] JOP_JGT  = 4'h2;
  localparam logic [3:0] JOP_JGE  = 4'h3;
  localparam logic [3:0] JOP_JSET = 4'h4;
  localparam logic [3:0] JOP_JNE  = 4'h5;
  localparam logic [3:0] JOP_JSGT = 4'h6;
  localparam logic [3:0] JOP_JSGE = 4'h7;
  localparam logic [3:0] JOP_CALL = 4'h8;
  localparam logic [3:0] JOP_EXIT = 4'h9;
  localparam logic [3:0] JOP_JLT  = 4'ha;
  localparam logic [3:0] JOP_JLE  = 4'hb;
  localparam logic [3:0] JOP_JSLT = 4'hc;
  localparam logic [3:0] JOP_JSLE = 4'hd;

  localparam logic [7:0] OPC_LDDW = 8'h18;
  localparam logic [2:0] MODE_MEM = 3'b011;

  localparam logic [1:0] SZ_W  = 2'd0;
  localparam logic [1:0] SZ_H  = 2'd1;
  localparam logic [1:0] SZ_B  = 2'd2;
  localparam logic [1:0] SZ_DW = 2'd3;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNSUP = 2'd1,
    ST_FAULT = 2'd2
  } status_e;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_LOAD = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

endpackage

/* rtl/core/ebpf_ie_if.sv */
interface ebpf_ie_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         opcode;
  logic [3:0]         dst_index;
  logic [3:0]         src_index;
  logic signed [15:0] offset;
  logic signed [31:0] immediate;

  modport source (output valid, opcode, dst_index, src_index, offset, immediate,
                  input ready);
  modport sink (input valid, opcode, dst_index, src_index, offset, immediate,
                output ready);
endinterface

interface ebpf_ie_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] advance;
  logic               exited;
  logic [63:0]        return_value;
  logic [1:0]         status;

  modport source (output valid, advance, exited, return_value, status, input ready);
  modport sink (input valid, advance, exited, return_value, status, output ready);
endinterface

/* rtl/core/ebpf_ie_ram.sv */
module ebpf_ie_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/ebpf_instruction_execute.sv */
// channel | dir | handshake          | payload
// inst_i  | in  | valid/ready        | opcode, dst_index, src_index, offset, immediate
// res_o   | out | valid/ready        | advance, exited, return_value, status
// cfg     | in  | cfg_we_i (no wait) | cfg_wdata_i = stack_base, also loads r10
// one item at a time: alu, jump, ld and store finish in exec, ldx in a load state (stack read)
// mul on a shared 32x32 multiplier, div and mod on a radix-2 divider, or in exec when by zero
// registers and stack sit in registered-read rams; results go to an output register
// a stalled output holds the next item in its last step until the register frees
// reset clears r0..r10 through per-register valid bits; no clearing pass
module ebpf_instruction_execute (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ebpf_ie_pkg::XLEN-1:0]   cfg_wdata_i,
  ebpf_ie_in_if.sink                     inst_i,
  ebpf_ie_out_if.source                  res_o
);
  import ebpf_ie_pkg::*;

  state_e state_q, state_d;

  logic [7:0]         opc_q;
  logic [3:0]         di_q, si_q;
  logic signed [15:0] off_q;
  logic signed [31:0] imm_q;
  logic [XLEN-1:0]    base_q;
  logic [REG_COUNT-1:0] vld_q;
  logic               dv_q, sv_q;

  logic               out_vld_q;
  logic [16:0]        adv_q;
  logic               exit_q;
  logic [XLEN-1:0]    ret_q;
  logic [1:0]         stat_q;

  logic [XLEN-1:0]    res_q;
  logic [1:0]         mcnt_q;
  logic [XLEN-1:0]    prod_q, acc_q;
  logic [XLEN-1:0]    quo_q, rem_q, dvs_q;
  logic [5:0]         dcnt_q;

  // register file read addressing
  logic [7:0]        a_opc;
  logic [3:0]        a_di, a_si, idx0;
  logic [REG_AW-1:0] ra0, ra1;
  logic [XLEN-1:0]   rf0, rf1;

  always_comb begin
    a_opc = (state_q == S_IDLE) ? inst_i.opcode : opc_q;
    a_di  = (state_q == S_IDLE) ? inst_i.dst_index : di_q;
    a_si  = (state_q == S_IDLE) ? inst_i.src_index : si_q;
    idx0  = (a_opc[2:0] == CLS_JMP && a_opc[7:4] == JOP_EXIT) ? 4'd0 : a_di;
    ra0   = idx0[REG_AW-1:0];
    ra1   = a_si[REG_AW-1:0];
  end

  logic              cm_rf_we;
  logic [XLEN-1:0]   cm_rf_val;
  logic              rf_we;
  logic [REG_AW-1:0] rf_wa;
  logic [XLEN-1:0]   rf_wd;

  assign rf_we = cfg_we_i | cm_rf_we;
  assign rf_wa = cfg_we_i ? REG_AW'(FP_REG) : di_q[REG_AW-1:0];
  assign rf_wd = cfg_we_i ? cfg_wdata_i : cm_rf_val;

  ebpf_ie_ram #(.Width(XLEN), .Depth(REG_COUNT)) u_rf_a (
    .clk_i, .we_i(rf_we), .waddr_i(rf_wa), .wdata_i(rf_wd), .raddr_i(ra0), .rdata_o(rf0)
  );
  ebpf_ie_ram #(.Width(XLEN), .Depth(REG_COUNT)) u_rf_b (
    .clk_i, .we_i(rf_we), .waddr_i(rf_wa), .wdata_i(rf_wd), .raddr_i(ra1), .rdata_o(rf1)
  );

  // decode
  logic [2:0]      cls;
  logic [3:0]      op;
  logic            regsrc, is64, usesrc;
  logic [XLEN-1:0] imm64, d, sreg, s;
  logic            di_bad, si_bad;
  logic [3:0]      nb;

  always_comb begin
    cls    = opc_q[2:0];
    op     = opc_q[7:4];
    regsrc = opc_q[3];
    is64   = (cls == CLS_ALU64);
    usesrc = regsrc && (cls == CLS_JMP || (op != OP_NEG && op != OP_END));
    imm64  = {{32{imm_q[31]}}, imm_q};
    d      = dv_q ? rf0 : '0;
    sreg   = sv_q ? rf1 : '0;
    s      = usesrc ? sreg : imm64;
    di_bad = di_q > 4'(FP_REG);
    si_bad = si_q > 4'(FP_REG);
    case (opc_q[4:3])
      SZ_W:    nb = 4'd4;
      SZ_H:    nb = 4'd2;
      SZ_B:    nb = 4'd1;
      default: nb = 4'd8;
    endcase
  end

  function automatic logic [XLEN-1:0] alu_calc(logic [3:0] f, logic [XLEN-1:0] a,
                                               logic [XLEN-1:0] b, logic w64);
    logic [XLEN-1:0] r;
    logic [31:0]     r32;
    logic [31:0]     a32, b32;
    a32 = a[31:0];
    b32 = b[31:0];
    case (f)
      OP_ADD:  begin r = a + b;  r32 = a32 + b32; end
      OP_SUB:  begin r = a - b;  r32 = a32 - b32; end
      OP_OR:   begin r = a | b;  r32 = a32 | b32; end
      OP_AND:  begin r = a & b;  r32 = a32 & b32; end
      OP_LSH:  begin r = a << b[5:0]; r32 = a32 << b32[4:0]; end
      OP_RSH:  begin r = a >> b[5:0]; r32 = a32 >> b32[4:0]; end
      OP_NEG:  begin r = '0 - a; r32 = 32'd0 - a32; end
      OP_XOR:  begin r = a ^ b;  r32 = a32 ^ b32; end
      OP_MOV:  begin r = b;      r32 = b32; end
      OP_ARSH: begin
        r   = $unsigned($signed(a) >>> b[5:0]);
        r32 = $unsigned($signed(a32) >>> b32[4:0]);
      end
      default: begin r = a; r32 = a32; end
    endcase
    return w64 ? r : {32'd0, r32};
  endfunction

  function automatic logic [XLEN-1:0] end_calc(logic [XLEN-1:0] a, logic [1:0] w,
                                               logic swap);
    logic [XLEN-1:0] r;
    case (w)
      2'd0:    r = swap ? {48'd0, a[7:0], a[15:8]} : {48'd0, a[15:0]};
      2'd1:    r = swap ? {32'd0, a[7:0], a[15:8], a[23:16], a[31:24]} : {32'd0, a[31:0]};
      default: r = swap ? {a[7:0], a[15:8], a[23:16], a[31:24],
                           a[39:32], a[47:40], a[55:48], a[63:56]} : a;
    endcase
    return r;
  endfunction

  // single-step result of the exec state
  state_e          x_next;
  logic [1:0]      x_stat;
  logic [16:0]     x_adv;
  logic            x_exit;
  logic [XLEN-1:0] x_ret;
  logic            x_wr;
  logic [XLEN-1:0] x_val;
  logic            x_st;
  logic [XLEN-1:0] st_val;
  logic            taken;
  logic            fault;
  logic [1:0]      end_w;
  logic            s_zero;

  always_comb begin
    x_next = S_IDLE;
    x_stat = ST_OK;
    x_adv  = 17'd1;
    x_exit = 1'b0;
    x_ret  = '0;
    x_wr   = 1'b0;
    x_val  = '0;
    x_st   = 1'b0;
    taken  = 1'b0;
    st_val = (cls == CLS_ST) ? imm64 : sreg;
    fault  = off_q[15] || (({2'b0, off_q} + 18'(nb)) > 18'(STACK_BYTES));
    s_zero = is64 ? (s == '0) : (s[31:0] == 32'd0);
    end_w  = 2'd3;
    if (imm_q == 32'sd16) begin
      end_w = 2'd0;
    end else if (imm_q == 32'sd32) begin
      end_w = 2'd1;
    end
    case (cls)
      CLS_ALU, CLS_ALU64: begin
        if (di_bad || (usesrc && si_bad)) begin
          x_stat = ST_UNSUP;
        end else if (op == OP_END) begin
          if (is64 || !(imm_q == 32'sd16 || imm_q == 32'sd32 || imm_q == 32'sd64)) begin
            x_stat = ST_UNSUP;
          end else begin
            x_wr  = 1'b1;
            x_val = end_calc(d, end_w, regsrc);
          end
        end else if (op inside {4'he, 4'hf}) begin
          x_stat = ST_UNSUP;
        end else if (op == OP_MUL) begin
          x_next = S_MUL;
        end else if (op == OP_DIV || op == OP_MOD) begin
          if (s_zero) begin
            x_wr  = 1'b1;
            x_val = (op == OP_DIV) ? '0 : (is64 ? d : {32'd0, d[31:0]});
          end else begin
            x_next = S_DIV;
          end
        end else begin
          x_wr  = 1'b1;
          x_val = alu_calc(op, d, s, is64);
        end
      end
      CLS_JMP: begin
        if (op == JOP_EXIT) begin
          x_exit = 1'b1;
          x_adv  = 17'd0;
          x_ret  = d;
        end else if (op == JOP_CALL || op inside {4'he, 4'hf}) begin
          x_stat = ST_UNSUP;
        end else if (op != JOP_JA && (di_bad || (regsrc && si_bad))) begin
          x_stat = ST_UNSUP;
        end else begin
          case (op)
            JOP_JA:   taken = 1'b1;
            JOP_JEQ:  taken = d == s;
            JOP_JGT:  taken = d > s;
            JOP_JGE:  taken = d >= s;
            JOP_JSET: taken = (d & s) != '0;
            JOP_JNE:  taken = d != s;
            JOP_JSGT: taken = $signed(d) > $signed(s);
            JOP_JSGE: taken = $signed(d) >= $signed(s);
            JOP_JLT:  taken = d < s;
            JOP_JLE:  taken = d <= s;
            JOP_JSLT: taken = $signed(d) < $signed(s);
            JOP_JSLE: taken = $signed(d) <= $signed(s);
            default:  taken = 1'b0;
          endcase
          if (taken) begin
            x_adv = 17'd1 + {off_q[15], off_q};
          end
        end
      end
      CLS_LD: begin
        if (opc_q != OPC_LDDW || di_bad) begin
          x_stat = ST_UNSUP;
        end else begin
          x_wr  = 1'b1;
          x_val = imm64;
        end
      end
      CLS_LDX, CLS_ST, CLS_STX: begin
        if (opc_q[7:5] != MODE_MEM || di_bad || (cls != CLS_ST && si_bad)) begin
          x_stat = ST_UNSUP;
        end else if (((cls == CLS_LDX) ? sreg : d) != base_q || fault) begin
          x_stat = ST_FAULT;
        end else if (cls == CLS_LDX) begin
          x_next = S_LOAD;
        end else begin
          x_st = 1'b1;
        end
      end
      default: x_stat = ST_UNSUP;
    endcase
  end

  // stack lanes
  logic [2:0]       ln_j   [LANES];
  logic [ROW_W-1:0] ln_row [LANES];
  logic             ln_en  [LANES];
  logic [7:0]       ln_wd  [LANES];
  logic [7:0]       ln_rd  [LANES];
  logic             stk_we;
  logic [XLEN-1:0]  ld_val;
  logic [ROW_W-1:0] row0;

  assign row0 = off_q[BA_W-1:3];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      ln_j[k]   = 3'(k) - off_q[2:0];
      ln_en[k]  = {1'b0, ln_j[k]} < nb;
      ln_row[k] = row0 + ROW_W'(3'(k) < off_q[2:0]);
      ln_wd[k]  = st_val[{ln_j[k], 3'b000} +: 8];
    end
    for (int j = 0; j < LANES; j++) begin
      ld_val[j*8 +: 8] = (4'(j) < nb) ? ln_rd[3'(off_q[2:0] + 3'(j))] : 8'd0;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    ebpf_ie_ram #(.Width(8), .Depth(ROWS)) u_stk (
      .clk_i,
      .we_i(stk_we && ln_en[g]),
      .waddr_i(ln_row[g]),
      .wdata_i(ln_wd[g]),
      .raddr_i(ln_row[g]),
      .rdata_o(ln_rd[g])
    );
  end

  // shared multiplier and divider step
  logic [31:0]     mul_a, mul_b;
  logic [XLEN:0]   dtr;
  logic            dge;
  logic [XLEN-1:0] fin_val;

  always_comb begin
    mul_a = (mcnt_q == 2'd2) ? d[63:32] : d[31:0];
    mul_b = (mcnt_q == 2'd1) ? s[63:32] : s[31:0];
    dtr   = {rem_q, quo_q[XLEN-1]};
    dge   = dtr >= {1'b0, dvs_q};
    fin_val = (op == OP_DIV) ? quo_q : (op == OP_MOD) ? rem_q : res_q;
  end

  logic free, accept;
  assign free   = !out_vld_q || res_o.ready;
  assign accept = inst_i.valid && inst_i.ready;
  assign inst_i.ready = (state_q == S_IDLE);

  logic            commit;
  logic [1:0]      c_stat;
  logic [16:0]     c_adv;
  logic            c_exit;
  logic [XLEN-1:0] c_ret;

  always_comb begin
    state_d   = state_q;
    commit    = 1'b0;
    cm_rf_we  = 1'b0;
    cm_rf_val = x_val;
    stk_we    = 1'b0;
    c_stat    = ST_OK;
    c_adv     = 17'd1;
    c_exit    = 1'b0;
    c_ret     = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (x_next != S_IDLE) begin
          state_d = x_next;
        end else if (free) begin
          commit   = 1'b1;
          cm_rf_we = x_wr;
          stk_we   = x_st;
          c_stat   = x_stat;
          c_adv    = x_adv;
          c_exit   = x_exit;
          c_ret    = x_ret;
          state_d  = S_IDLE;
        end
      end
      S_MUL: begin
        if (mcnt_q == 2'd3) begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        if (dcnt_q == 6'd63) begin
          state_d = S_FIN;
        end
      end
      S_LOAD: begin
        if (free) begin
          commit    = 1'b1;
          cm_rf_we  = 1'b1;
          cm_rf_val = ld_val;
          state_d   = S_IDLE;
        end
      end
      S_FIN: begin
        if (free) begin
          commit    = 1'b1;
          cm_rf_we  = 1'b1;
          cm_rf_val = fin_val;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      vld_q     <= '0;
      base_q    <= '0;
      out_vld_q <= 1'b0;
      mcnt_q    <= '0;
      dcnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (rf_we) begin
        vld_q[rf_wa] <= 1'b1;
      end
      if (commit) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (state_q == S_EXEC) begin
        mcnt_q <= '0;
        dcnt_q <= '0;
      end else begin
        if (state_q == S_MUL) begin
          mcnt_q <= mcnt_q + 2'd1;
        end
        if (state_q == S_DIV) begin
          dcnt_q <= dcnt_q + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      opc_q <= inst_i.opcode;
      di_q  <= inst_i.dst_index;
      si_q  <= inst_i.src_index;
      off_q <= inst_i.offset;
      imm_q <= inst_i.immediate;
      dv_q  <= (idx0 <= 4'(FP_REG)) && vld_q[ra0];
      sv_q  <= (a_si <= 4'(FP_REG)) && vld_q[ra1];
    end
    if (commit) begin
      adv_q  <= c_adv;
      exit_q <= c_exit;
      ret_q  <= c_ret;
      stat_q <= c_stat;
    end
    if (state_q == S_EXEC) begin
      quo_q <= is64 ? d : {32'd0, d[31:0]};
      rem_q <= '0;
      dvs_q <= is64 ? s : {32'd0, s[31:0]};
    end else if (state_q == S_DIV) begin
      quo_q <= {quo_q[XLEN-2:0], dge};
      rem_q <= dge ? XLEN'(dtr - {1'b0, dvs_q}) : dtr[XLEN-1:0];
    end
    if (state_q == S_MUL) begin
      prod_q <= {32'd0, mul_a} * {32'd0, mul_b};
      case (mcnt_q)
        2'd1:    acc_q <= prod_q;
        2'd2:    acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
        2'd3:    res_q <= is64 ? {acc_q[63:32] + prod_q[31:0], acc_q[31:0]}
                               : {32'd0, acc_q[31:0]};
        default: acc_q <= acc_q;
      endcase
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.advance      = $signed(adv_q);
  assign res_o.exited       = exit_q;
  assign res_o.return_value = ret_q;
  assign res_o.status       = stat_q;

endmodule

/* rtl/core/ebpf_ie_checker.sv */
`include "ebpf_instruction_execute_defines.svh"

module ebpf_ie_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [16:0] advance_i,
  input logic        exited_i,
  input logic [63:0] return_value_i,
  input logic [1:0]  status_i
);
  import ebpf_ie_pkg::*;

  `EIE_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_i, !in_ready_i, "item taken while busy")
  `EIE_ASSERT_IMPL(a_exit_shape, out_valid_i && exited_i, advance_i == 17'd0 && status_i == ST_OK, "bad exit item")
  `EIE_ASSERT_IMPL(a_err_shape, out_valid_i && status_i != ST_OK, advance_i == 17'd1 && !exited_i, "bad error item")
  `EIE_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(advance_i) && $stable(return_value_i) && $stable(status_i), "stalled item changed")

endmodule

bind ebpf_instruction_execute ebpf_ie_checker u_ebpf_ie_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (inst_i.valid),
  .in_ready_i     (inst_i.ready),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .advance_i      (res_o.advance),
  .exited_i       (res_o.exited),
  .return_value_i (res_o.return_value),
  .status_i       (res_o.status)
);
